>>> src/ahlv_pkg.sv
`timescale 1ns / 1ps

package ahlv_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int KNEE_W     = 15;
  localparam int VOL_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Full-scale volume (unity gain), also the divisor of the gain stage
  localparam logic [VOL_W-1:0] VOL_FULL = 7'd100;

  // Register reset values
  localparam logic signed [COEF_W-1:0] RST_B0   = 18'sd61995;
  localparam logic signed [COEF_W-1:0] RST_B1   = -18'sd123991;
  localparam logic signed [COEF_W-1:0] RST_B2   = 18'sd61995;
  localparam logic signed [COEF_W-1:0] RST_A1   = -18'sd123800;
  localparam logic signed [COEF_W-1:0] RST_A2   = 18'sd58646;
  localparam logic [KNEE_W-1:0]        RST_KNEE = 15'd26000;
  localparam logic [VOL_W-1:0]         RST_VOL  = 7'd100;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_B1     = 3'd1,
    REG_B2     = 3'd2,
    REG_A1     = 3'd3,
    REG_A2     = 3'd4,
    REG_KNEE   = 3'd5,
    REG_VOLUME = 3'd6,
    REG_ENABLE = 3'd7
  } cfg_reg_e;

  // Biquad coefficient set handed to the MAC
  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

endpackage

>>> src/audio_highpass_limiter_volume_core.sv
`timescale 1ns / 1ps
// Path of a sample with the filter on: input transfer, MAC start, the
// bit-serial MAC over the five products, post-processing (POST, LIM1, LIM2),
// the serial volume multiply/divide, then the output register; in bypass
// the sample goes straight to the volume stage. A new sample is taken only in idle, once the last result is loaded.
// Reset (async, active low) loads the default coefficients, knee 26000,
// volume 100, filter on, and clears the filter history and the output valid flag.
module audio_highpass_limiter_volume_core #(
  parameter int COEF_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS  = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [15:0]                            s_axis_tdata_i,  // [15:0] sample_in
  input  logic                                   s_axis_tlast_i,  // end_of_block
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [15:0]                            m_axis_tdata_o,  // [15:0] sample_out
  output logic                                   m_axis_tlast_o,  // end_of_block_out
  input  logic                                   cfg_we_i,
  input  logic [ahlv_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [ahlv_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int SW = ahlv_pkg::SAMPLE_W;
  localparam int CW = ahlv_pkg::COEF_W;
  localparam int KW = ahlv_pkg::KNEE_W;
  localparam int VW = ahlv_pkg::VOL_W;
  localparam int YW = CW + OUT_FRAC_BITS;
  localparam int AW = 2 * CW + OUT_FRAC_BITS + 2;
  localparam int SH = COEF_FRAC_BITS + OUT_FRAC_BITS;

  localparam logic signed [AW-1:0] Y_MAX   = AW'((64'sd1 <<< (YW - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] Y_MIN   = AW'(-(64'sd1 <<< (YW - 1)));
  localparam logic signed [AW-1:0] S_MAX   = AW'((1 <<< (SW - 1)) - 1);
  localparam logic signed [AW-1:0] S_MIN   = AW'(-(1 <<< (SW - 1)));
  localparam logic signed [AW-1:0] A_ONE   = AW'(1);
  localparam logic signed [AW-1:0] A_THREE = AW'(3);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MSTART = 9'b000000010,
    ST_MAC    = 9'b000000100,
    ST_POST   = 9'b000001000,
    ST_LIM1   = 9'b000010000,
    ST_LIM2   = 9'b000100000,
    ST_VSTART = 9'b001000000,
    ST_VOL    = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  // Configuration registers
  ahlv_pkg::coef_set_t coef_q;
  logic [KW-1:0]       knee_q;
  logic [VW-1:0]       volume_q;
  logic                enable_q;

  // Filter history
  logic signed [SW-1:0] in1_q, in2_q;
  logic signed [YW-1:0] y1_q, y2_q;

  // Control and per-sample datapath
  state_e               state_q, state_d;
  logic signed [SW-1:0] x_q;
  logic                 eob_q;
  logic signed [AW-1:0] yint_q;
  logic signed [AW-1:0] d_q;
  logic                 over_q, under_q;
  logic signed [SW-1:0] s_q;
  logic                 out_valid_q;
  logic [SW-1:0]        out_data_q;
  logic                 out_last_q;

  logic                 s_fire;
  logic                 can_load;
  logic                 mac_done;
  logic signed [AW-1:0] mac_acc;
  logic                 vol_done;
  logic signed [SW-1:0] vol_sample;

  logic signed [AW-1:0] stored_full;
  logic signed [YW-1:0] stored;
  logic signed [AW-1:0] q_floor;
  logic signed [AW-1:0] yint;
  logic signed [AW-1:0] th;
  logic signed [AW-1:0] r_over, r_under;
  logic signed [SW-1:0] s_lim;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign can_load = !out_valid_q || m_axis_tready_i;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= ahlv_pkg::RST_B0;
      coef_q.b1 <= ahlv_pkg::RST_B1;
      coef_q.b2 <= ahlv_pkg::RST_B2;
      coef_q.a1 <= ahlv_pkg::RST_A1;
      coef_q.a2 <= ahlv_pkg::RST_A2;
      knee_q    <= ahlv_pkg::RST_KNEE;
      volume_q  <= ahlv_pkg::RST_VOL;
      enable_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (ahlv_pkg::cfg_reg_e'(cfg_idx_i))
        ahlv_pkg::REG_B0:     coef_q.b0 <= cfg_data_i[CW-1:0];
        ahlv_pkg::REG_B1:     coef_q.b1 <= cfg_data_i[CW-1:0];
        ahlv_pkg::REG_B2:     coef_q.b2 <= cfg_data_i[CW-1:0];
        ahlv_pkg::REG_A1:     coef_q.a1 <= cfg_data_i[CW-1:0];
        ahlv_pkg::REG_A2:     coef_q.a2 <= cfg_data_i[CW-1:0];
        ahlv_pkg::REG_KNEE:   knee_q    <= cfg_data_i[KW-1:0];
        ahlv_pkg::REG_VOLUME: volume_q  <= cfg_data_i[VW-1:0];
        ahlv_pkg::REG_ENABLE: enable_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Bit-serial biquad MAC
  ahlv_mac #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_MSTART),
    .coef_i  (coef_q),
    .x0_i    (x_q),
    .x1_i    (in1_q),
    .x2_i    (in2_q),
    .y1_i    (y1_q),
    .y2_i    (y2_q),
    .done_o  (mac_done),
    .acc_o   (mac_acc)
  );

  // Serial volume scaler
  ahlv_vol u_vol (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == ST_VSTART),
    .sample_i (s_q),
    .volume_i (volume_q),
    .done_o   (vol_done),
    .sample_o (vol_sample)
  );

  // Filter output: floor to stored precision with saturation, and the
  // integer sample truncated toward zero
  always_comb begin
    stored_full = mac_acc >>> COEF_FRAC_BITS;
    if (stored_full > Y_MAX) begin
      stored = YW'(Y_MAX);
    end else if (stored_full < Y_MIN) begin
      stored = YW'(Y_MIN);
    end else begin
      stored = YW'(stored_full);
    end
    q_floor = mac_acc >>> SH;
    yint    = (mac_acc[AW-1] && (|mac_acc[SH-1:0])) ? (q_floor + A_ONE) : q_floor;
  end

  // Soft knee: excess over the threshold divided by four toward zero
  always_comb begin
    th      = AW'({1'b0, knee_q});
    r_over  = th + (d_q >>> 2);
    r_under = ((d_q + A_THREE) >>> 2) - th;
    if (over_q) begin
      s_lim = (r_over > S_MAX) ? SW'(S_MAX) : SW'(r_over);
    end else if (under_q) begin
      s_lim = (r_under < S_MIN) ? SW'(S_MIN) : SW'(r_under);
    end else begin
      s_lim = SW'(yint_q);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_fire) state_d = enable_q ? ST_MSTART : ST_VSTART;
      ST_MSTART: state_d = ST_MAC;
      ST_MAC:    if (mac_done) state_d = ST_POST;
      ST_POST:   state_d = ST_LIM1;
      ST_LIM1:   state_d = ST_LIM2;
      ST_LIM2:   state_d = ST_VSTART;
      ST_VSTART: state_d = ST_VOL;
      ST_VOL:    if (vol_done) state_d = ST_OUT;
      ST_OUT:    if (can_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Filter history, updated once per filtered sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in1_q <= '0;
      in2_q <= '0;
      y1_q  <= '0;
      y2_q  <= '0;
    end else if (state_q == ST_POST) begin
      in2_q <= in1_q;
      in1_q <= x_q;
      y2_q  <= y1_q;
      y1_q  <= stored;
    end
  end

  // Per-sample payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      x_q   <= s_axis_tdata_i;
      eob_q <= s_axis_tlast_i;
      if (!enable_q) begin
        s_q <= s_axis_tdata_i;
      end
    end
    if (state_q == ST_POST) begin
      yint_q <= yint;
    end
    if (state_q == ST_LIM1) begin
      over_q  <= (yint_q > th);
      under_q <= (yint_q < -th);
      d_q     <= (yint_q > th) ? (yint_q - th) : (yint_q + th);
    end
    if (state_q == ST_LIM2) begin
      s_q <= s_lim;
    end
    if (state_q == ST_OUT && can_load) begin
      out_data_q <= vol_sample;
      out_last_q <= eob_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && can_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> src/ahlv_mac.sv
`timescale 1ns / 1ps

// Bit-serial biquad multiply-accumulate: one coefficient bit per cycle,
// five products in turn. Feedforward terms are pre-scaled by the output
// fraction bits, feedback terms are subtracted.
module ahlv_mac #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  ahlv_pkg::coef_set_t                           coef_i,
  input  logic signed [ahlv_pkg::SAMPLE_W-1:0]          x0_i,
  input  logic signed [ahlv_pkg::SAMPLE_W-1:0]          x1_i,
  input  logic signed [ahlv_pkg::SAMPLE_W-1:0]          x2_i,
  input  logic signed [ahlv_pkg::COEF_W+OUT_FRAC_BITS-1:0] y1_i,
  input  logic signed [ahlv_pkg::COEF_W+OUT_FRAC_BITS-1:0] y2_i,
  output logic                                          done_o,
  output logic signed [2*ahlv_pkg::COEF_W+OUT_FRAC_BITS+1:0] acc_o
);

  localparam int CW    = ahlv_pkg::COEF_W;
  localparam int AW    = 2 * CW + OUT_FRAC_BITS + 2;
  localparam int BIT_W = $clog2(CW);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(CW - 1);

  typedef enum logic [2:0] {
    T_B0 = 3'd0,
    T_B1 = 3'd1,
    T_B2 = 3'd2,
    T_A1 = 3'd3,
    T_A2 = 3'd4
  } term_e;

  logic                 busy_q;
  logic                 done_q;
  term_e                term_q;
  logic [BIT_W-1:0]     bit_q;
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [AW-1:0] mcand_q;
  logic [CW-1:0]        mplier_q;

  term_e                sel;
  logic signed [AW-1:0] ld_mcand;
  logic [CW-1:0]        ld_mplier;
  logic signed [AW-1:0] addend;
  logic                 neg;
  logic                 last_bit;

  // Operand fetch for the term about to start
  always_comb begin
    sel = start_i ? T_B0 : term_e'(term_q + 3'd1);
    unique case (sel)
      T_B0: begin
        ld_mcand  = AW'(x0_i) <<< OUT_FRAC_BITS;
        ld_mplier = coef_i.b0;
      end
      T_B1: begin
        ld_mcand  = AW'(x1_i) <<< OUT_FRAC_BITS;
        ld_mplier = coef_i.b1;
      end
      T_B2: begin
        ld_mcand  = AW'(x2_i) <<< OUT_FRAC_BITS;
        ld_mplier = coef_i.b2;
      end
      T_A1: begin
        ld_mcand  = AW'(y1_i);
        ld_mplier = coef_i.a1;
      end
      T_A2: begin
        ld_mcand  = AW'(y2_i);
        ld_mplier = coef_i.a2;
      end
      default: begin
        ld_mcand  = '0;
        ld_mplier = '0;
      end
    endcase
  end

  // One partial product per cycle; the coefficient MSB carries negative weight
  always_comb begin
    last_bit = (bit_q == LAST_BIT);
    addend   = mplier_q[0] ? mcand_q : '0;
    neg      = ((term_q == T_A1) || (term_q == T_A2)) ^ last_bit;
    acc_d    = neg ? (acc_q - addend) : (acc_q + addend);
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      term_q <= T_B0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        term_q <= T_B0;
        bit_q  <= '0;
      end else if (busy_q) begin
        if (last_bit) begin
          bit_q <= '0;
          if (term_q == T_A2) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            term_q <= sel;
          end
        end else begin
          bit_q <= bit_q + 1'b1;
        end
      end
    end
  end

  // Shift registers and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= ld_mcand;
      mplier_q <= ld_mplier;
    end else if (busy_q) begin
      acc_q <= acc_d;
      if (last_bit) begin
        mcand_q  <= ld_mcand;
        mplier_q <= ld_mplier;
      end else begin
        mcand_q  <= mcand_q <<< 1;
        mplier_q <= mplier_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

>>> src/ahlv_vol.sv
`timescale 1ns / 1ps

// Volume scaling: |s| * volume by shift-and-add over the volume bits, then
// a restoring division by 100, one quotient bit per cycle. Sign reapplied
// at the end, so the result truncates toward zero.
module ahlv_vol (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [ahlv_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [ahlv_pkg::VOL_W-1:0]           volume_i,
  output logic                                 done_o,
  output logic signed [ahlv_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int SW     = ahlv_pkg::SAMPLE_W;
  localparam int VW     = ahlv_pkg::VOL_W;
  localparam int PW     = SW + VW;
  localparam int CNT_W  = $clog2(PW);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(VW - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PW - 1);

  typedef enum logic [2:0] {
    V_IDLE = 3'b001,
    V_MUL  = 3'b010,
    V_DIV  = 3'b100
  } vstate_e;

  vstate_e          state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic             neg_q;
  logic [PW-1:0]    mcand_q;
  logic [VW-1:0]    mplier_q;
  logic [PW-1:0]    prod_q;
  logic [VW-1:0]    rem_q;

  logic signed [SW:0] mag_s;
  logic [VW:0]        rem_sh;
  logic               ge;
  logic [VW:0]        rem_sub;
  logic [SW:0]        quot;
  logic [SW:0]        res_full;

  // Magnitude, division step, final sign
  always_comb begin
    mag_s    = sample_i[SW-1] ? -(SW+1)'(sample_i) : (SW+1)'(sample_i);
    rem_sh   = {rem_q, prod_q[PW-1]};
    ge       = (rem_sh >= {1'b0, ahlv_pkg::VOL_FULL});
    rem_sub  = rem_sh - {1'b0, ahlv_pkg::VOL_FULL};
    quot     = prod_q[SW:0];
    res_full = neg_q ? (~quot + 1'b1) : quot;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= V_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        V_IDLE: begin
          if (start_i) begin
            state_q <= V_MUL;
            cnt_q   <= '0;
          end
        end
        V_MUL: begin
          if (cnt_q == MUL_LAST) begin
            state_q <= V_DIV;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        V_DIV: begin
          if (cnt_q == DIV_LAST) begin
            state_q <= V_IDLE;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= V_IDLE;
      endcase
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    if (state_q == V_IDLE && start_i) begin
      neg_q    <= sample_i[SW-1];
      mcand_q  <= PW'(mag_s[SW-1:0]);
      mplier_q <= (volume_i > ahlv_pkg::VOL_FULL) ? ahlv_pkg::VOL_FULL : volume_i;
      prod_q   <= '0;
    end else if (state_q == V_MUL) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      rem_q    <= '0;
    end else if (state_q == V_DIV) begin
      rem_q  <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      prod_q <= {prod_q[PW-2:0], ge};
    end
  end

  assign done_o   = done_q;
  assign sample_o = res_full[SW-1:0];

endmodule

>>> src/ahlv_chk.sv
`timescale 1ns / 1ps

// Port-level checks for the audio core
module ahlv_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_i,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [15:0] m_tdata_i,
  input logic        m_tlast_i
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pend_q;

  assign in_fire  = s_tvalid_i && s_tready_i;
  assign out_fire = m_tvalid_i && m_tready_i;

  // Samples taken in but not yet handed out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  // No result without a sample behind it
  a_no_extra_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (pend_q != 2'd0))
    else $error("output transfer without pending input");

  // At most one sample in work and one in the output register
  a_max_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 2'd2) |-> !s_tready_i)
    else $error("input accepted with output register and core both busy");

  // Stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tready_i) |=>
      (m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i)))
    else $error("output changed while stalled");

  // Nothing on the output right out of reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_tvalid_i)
    else $error("output valid right after reset");

endmodule

bind audio_highpass_limiter_volume_core ahlv_chk u_ahlv_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o)
);
